FILE: rtl/core/ruat_pkg.sv
package ruat_pkg;

   localparam int unsigned PEER_W   = 48;
   localparam int unsigned SEQ_W    = 16;
   localparam int unsigned HANDLE_W = 8;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned KIND_W   = 4;
   localparam int unsigned CSR_W    = 8;
   localparam int unsigned CSR_IDX_W = 2;

   localparam int unsigned OUT_ENTRIES_DEF = 16;
   localparam int unsigned IN_ENTRIES_DEF  = 32;

   localparam logic [7:0]  RESEND_WAIT_RST = 8'd2;
   localparam logic [7:0]  HOLD_TIME_RST   = 8'd5;
   localparam logic [2:0]  RETRY_LIMIT_RST = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_RESEND_WAIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 2'd2;

   localparam logic [PEER_W-1:0] BCAST_PEER = {PEER_W{1'b1}};

   typedef enum logic [1:0] {
      ACT_SEND = 2'd0,
      ACT_ACK  = 2'd1,
      ACT_RECV = 2'd2,
      ACT_TICK = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      K_TX_NEW     = 4'd0,
      K_TX_UNTRACK = 4'd1,
      K_RETX       = 4'd2,
      K_FAILED     = 4'd3,
      K_DELIVER    = 4'd4,
      K_SEND_ACK   = 4'd5,
      K_ACK_UNMAT  = 4'd6,
      K_OUT_FULL   = 4'd7,
      K_ACK_MATCH  = 4'd8
   } kind_type;

   // operation broadcast to the cells of a row
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_TICK  = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic [TIME_W-1:0] now;
      logic [7:0]        wait_time;
      logic [2:0]        retry_limit;
   } tick_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [PEER_W-1:0] peer;
      logic [SEQ_W-1:0]  seq;
      logic [HANDLE_W-1:0] handle;
      logic              fail;
      logic              resend;
   } out_view_type;

   function automatic logic expired(input logic [TIME_W-1:0] stamp,
                                    input logic [7:0] wait_time,
                                    input logic [TIME_W-1:0] now);
      logic [TIME_W:0] sum;
      sum = {1'b0, stamp} + {{(TIME_W-7){1'b0}}, wait_time};
      return sum < {1'b0, now};
   endfunction

endpackage

FILE: rtl/core/ruat_out_cell.sv
module ruat_out_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  ruat_pkg::cell_op_type         op,
   input  logic                          sel,
   input  logic [ruat_pkg::PEER_W-1:0]   wr_peer,
   input  logic [ruat_pkg::SEQ_W-1:0]    wr_seq,
   input  logic [ruat_pkg::HANDLE_W-1:0] wr_handle,
   input  ruat_pkg::tick_ctl_type        tick,
   input  logic [ruat_pkg::PEER_W-1:0]   key_peer,
   input  logic [ruat_pkg::SEQ_W-1:0]    key_seq,
   output logic                          hit,
   output ruat_pkg::out_view_type        view
);
   import ruat_pkg::*;

   logic                valid_ff, valid_in;
   logic [PEER_W-1:0]   peer_ff, peer_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [3:0]          retries_ff, retries_in;
   logic [TIME_W-1:0]   stamp_ff, stamp_in;
   logic                fail, resend;

   assign fail   = valid_ff && (retries_ff > {1'b0, tick.retry_limit});
   assign resend = valid_ff && !fail && expired(stamp_ff, tick.wait_time, tick.now);
   assign hit    = valid_ff && (peer_ff == key_peer) && (seq_ff == key_seq);
   assign view   = '{valid: valid_ff, peer: peer_ff, seq: seq_ff, handle: handle_ff,
                     fail: fail, resend: resend};

   always_comb begin
      valid_in   = valid_ff;
      peer_in    = peer_ff;
      seq_in     = seq_ff;
      handle_in  = handle_ff;
      retries_in = retries_ff;
      stamp_in   = stamp_ff;
      if (sel) begin
         case (op)
            OP_WRITE: begin
               valid_in   = 1'b1;
               peer_in    = wr_peer;
               seq_in     = wr_seq;
               handle_in  = wr_handle;
               retries_in = '0;
               stamp_in   = tick.now;
            end
            OP_CLEAR: valid_in = 1'b0;
            OP_TICK: begin
               if (fail) valid_in = 1'b0;
               else if (resend) begin
                  stamp_in = tick.now;
                  if (retries_ff != 4'hF) retries_in = retries_ff + 4'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      peer_ff    <= peer_in;
      seq_ff     <= seq_in;
      handle_ff  <= handle_in;
      retries_ff <= retries_in;
      stamp_ff   <= stamp_in;
   end

endmodule

FILE: rtl/core/ruat_in_cell.sv
module ruat_in_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  ruat_pkg::cell_op_type       op,
   input  logic                        sel,
   input  logic [ruat_pkg::PEER_W-1:0] key_peer,
   input  logic [ruat_pkg::SEQ_W-1:0]  key_seq,
   input  ruat_pkg::tick_ctl_type      tick,
   output logic                        valid,
   output logic                        hit
);
   import ruat_pkg::*;

   logic              valid_ff, valid_in;
   logic [PEER_W-1:0] peer_ff, peer_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [TIME_W-1:0] stamp_ff, stamp_in;

   assign valid = valid_ff;
   assign hit   = valid_ff && (peer_ff == key_peer) && (seq_ff == key_seq);

   always_comb begin
      valid_in = valid_ff;
      peer_in  = peer_ff;
      seq_in   = seq_ff;
      stamp_in = stamp_ff;
      case (op)
         OP_WRITE: if (sel) begin
            valid_in = 1'b1;
            peer_in  = key_peer;
            seq_in   = key_seq;
            stamp_in = tick.now;
         end
         OP_TICK: if (valid_ff && expired(stamp_ff, tick.wait_time, tick.now))
            valid_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      peer_ff  <= peer_in;
      seq_ff   <= seq_in;
      stamp_ff <= stamp_in;
   end

endmodule

FILE: rtl/core/reliable_unicast_ack_tracker.sv
// Reliable unicast ack tracker.
// Input channel req_*: one event per item (send, ack, receive, tick) with
// valid/stall handshake. Result channel rsp_*: zero or more result items per
// event, the final one flagged by rsp_last. A tick that has nothing to report
// yields no result item.
// Config: csr_wr_en with csr_index/csr_data; the user must write only while idle, which the block does not enforce.
// Timing: send, ack and receive are registered on accept, then matched against
// the cell rows in S_EXEC, which loads the output register once it is free;
// receive gives up to two results. Send, ack and a duplicate receive pass
// S_EXEC and S_DRAIN; a new receive passes S_EXEC, S_ACK2 and S_DRAIN.
// A tick walks the outbound cell row one entry per cycle while the output
// register is not held by rsp_stall, then purges the inbound row in S_PURGE
// before the next item is taken.
// One event is in flight at a time; the next is taken once its last result
// has left the output register.
// Reset: synchronous, clears all valid bits, next sequence number becomes 1,
// registers take their defaults. No clearing pass is needed.
// Stall: the output register holds while rsp_stall is high and the walk or
// match waits behind it; nothing is dropped.
module reliable_unicast_ack_tracker #(
   parameter int unsigned OUT_ENTRIES = ruat_pkg::OUT_ENTRIES_DEF,
   parameter int unsigned IN_ENTRIES  = ruat_pkg::IN_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_action,
   input  logic [ruat_pkg::PEER_W-1:0]        req_peer,
   input  logic [ruat_pkg::SEQ_W-1:0]         req_seq,
   input  logic [ruat_pkg::HANDLE_W-1:0]      req_handle,
   input  logic [ruat_pkg::TIME_W-1:0]        req_now,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ruat_pkg::KIND_W-1:0]        rsp_kind,
   output logic [ruat_pkg::PEER_W-1:0]        rsp_out_peer,
   output logic [ruat_pkg::SEQ_W-1:0]         rsp_out_seq,
   output logic [ruat_pkg::HANDLE_W-1:0]      rsp_out_handle,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [ruat_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ruat_pkg::CSR_W-1:0]         csr_data
);
   import ruat_pkg::*;

   localparam int unsigned OW = (OUT_ENTRIES > 1) ? $clog2(OUT_ENTRIES) : 1;
   localparam int unsigned IW = (IN_ENTRIES > 1) ? $clog2(IN_ENTRIES) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_ACK2, S_WALK, S_PURGE, S_DRAIN
   } state_type;

   state_type           state_ff;
   logic [7:0]          resend_wait_ff, hold_time_ff;
   logic [2:0]          retry_limit_ff;
   logic [SEQ_W-1:0]    next_seq_ff;
   action_type          act_ff;
   logic [PEER_W-1:0]   peer_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [OW-1:0]       idx_ff;

   logic                ov_ff;
   logic [KIND_W-1:0]   okind_ff;
   logic [PEER_W-1:0]   opeer_ff;
   logic [SEQ_W-1:0]    oseq_ff;
   logic [HANDLE_W-1:0] ohandle_ff;
   logic                olast_ff;

   logic out_free;
   assign out_free  = !ov_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign rsp_valid      = ov_ff;
   assign rsp_kind       = okind_ff;
   assign rsp_out_peer   = opeer_ff;
   assign rsp_out_seq    = oseq_ff;
   assign rsp_out_handle = ohandle_ff;
   assign rsp_last       = olast_ff;

   tick_ctl_type otick, itick;
   assign otick = '{now: now_ff, wait_time: resend_wait_ff, retry_limit: retry_limit_ff};
   assign itick = '{now: now_ff, wait_time: hold_time_ff, retry_limit: retry_limit_ff};

   // outbound row
   cell_op_type      o_op;
   logic [OUT_ENTRIES-1:0] o_sel, o_hit, o_valid;
   out_view_type     o_view [OUT_ENTRIES];

   // inbound row
   cell_op_type      i_op;
   logic [IN_ENTRIES-1:0] i_sel, i_hit, i_valid;

   genvar g;
   generate
      for (g = 0; g < OUT_ENTRIES; g++) begin : g_out
         ruat_out_cell u_cell (
            .clock, .reset, .op(o_op), .sel(o_sel[g]),
            .wr_peer(peer_ff), .wr_seq(next_seq_ff), .wr_handle(handle_ff),
            .tick(otick), .key_peer(peer_ff), .key_seq(seq_ff),
            .hit(o_hit[g]), .view(o_view[g]));
         assign o_valid[g] = o_view[g].valid;
      end
      for (g = 0; g < IN_ENTRIES; g++) begin : g_in
         ruat_in_cell u_cell (
            .clock, .reset, .op(i_op), .sel(i_sel[g]),
            .key_peer(peer_ff), .key_seq(seq_ff), .tick(itick),
            .valid(i_valid[g]), .hit(i_hit[g]));
      end
   endgenerate

   // lowest-set one-hot picks
   logic [OUT_ENTRIES-1:0] o_free_oh, o_hit_oh;
   logic [IN_ENTRIES-1:0]  i_free_oh;
   assign o_free_oh = ~o_valid & (o_valid + 1'b1);
   assign o_hit_oh  = o_hit & (~o_hit + 1'b1);
   assign i_free_oh = ~i_valid & (i_valid + 1'b1);

   logic [HANDLE_W-1:0] hit_handle;
   always_comb begin
      hit_handle = '0;
      for (int k = 0; k < OUT_ENTRIES; k++)
         if (o_hit_oh[k]) hit_handle = o_view[k].handle;
   end

   // entries past the walk position still have something to report;
   // they are untouched until the walk reaches them
   logic more_after;
   always_comb begin
      more_after = 1'b0;
      for (int k = 0; k < OUT_ENTRIES; k++)
         if (k > int'(idx_ff) && (o_view[k].fail || o_view[k].resend)) more_after = 1'b1;
   end

   out_view_type cur;
   logic         walk_end;
   assign cur      = o_view[idx_ff];
   assign walk_end = (idx_ff == OW'(OUT_ENTRIES - 1));

   // cell-row control for this cycle
   always_comb begin
      o_op  = OP_NONE;
      o_sel = '0;
      i_op  = OP_NONE;
      i_sel = '0;
      if (state_ff == S_EXEC && out_free) begin
         case (act_ff)
            ACT_SEND: if (peer_ff != BCAST_PEER) begin
               o_op = OP_WRITE; o_sel = o_free_oh;
            end
            ACT_ACK: begin
               o_op = OP_CLEAR; o_sel = o_hit_oh;
            end
            ACT_RECV: if (i_hit == '0) begin
               i_op = OP_WRITE; i_sel = i_free_oh;
            end
            default: ;
         endcase
      end
      if (state_ff == S_WALK && out_free) begin
         o_op = OP_TICK;
         o_sel[idx_ff] = 1'b1;
      end
      if (state_ff == S_PURGE) i_op = OP_TICK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         resend_wait_ff <= RESEND_WAIT_RST;
         hold_time_ff   <= HOLD_TIME_RST;
         retry_limit_ff <= RETRY_LIMIT_RST;
         next_seq_ff    <= SEQ_W'(1);
         ov_ff          <= 1'b0;
         idx_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RESEND_WAIT: resend_wait_ff <= csr_data;
               CSR_HOLD_TIME:   hold_time_ff   <= csr_data;
               CSR_RETRY_LIMIT: retry_limit_ff <= csr_data[2:0];
               default: ;
            endcase
         end
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_valid) begin
               act_ff    <= action_type'(req_action);
               peer_ff   <= req_peer;
               seq_ff    <= req_seq;
               handle_ff <= req_handle;
               now_ff    <= req_now;
               idx_ff    <= '0;
               state_ff  <= (action_type'(req_action) == ACT_TICK) ? S_WALK : S_EXEC;
            end
            S_EXEC: if (out_free) begin
               ov_ff      <= 1'b1;
               opeer_ff   <= peer_ff;
               olast_ff   <= 1'b1;
               state_ff   <= S_DRAIN;
               case (act_ff)
                  ACT_SEND: begin
                     ohandle_ff <= handle_ff;
                     if (peer_ff == BCAST_PEER) begin
                        okind_ff <= K_TX_UNTRACK; oseq_ff <= '0;
                     end else if (o_valid == '1) begin
                        okind_ff <= K_OUT_FULL; oseq_ff <= '0;
                     end else begin
                        okind_ff    <= K_TX_NEW;
                        oseq_ff     <= next_seq_ff;
                        next_seq_ff <= next_seq_ff + SEQ_W'(1);
                     end
                  end
                  ACT_ACK: begin
                     oseq_ff <= seq_ff;
                     if (o_hit == '0) begin
                        okind_ff <= K_ACK_UNMAT; ohandle_ff <= '0;
                     end else begin
                        okind_ff <= K_ACK_MATCH; ohandle_ff <= hit_handle;
                     end
                  end
                  default: begin
                     oseq_ff    <= seq_ff;
                     ohandle_ff <= handle_ff;
                     if (i_hit == '0) begin
                        okind_ff <= K_DELIVER; olast_ff <= 1'b0; state_ff <= S_ACK2;
                     end else okind_ff <= K_SEND_ACK;
                  end
               endcase
            end
            S_ACK2: if (out_free) begin
               ov_ff    <= 1'b1;
               okind_ff <= K_SEND_ACK;
               olast_ff <= 1'b1;
               state_ff <= S_DRAIN;
            end
            S_WALK: if (out_free) begin
               if (cur.fail || cur.resend) begin
                  ov_ff      <= 1'b1;
                  okind_ff   <= cur.fail ? K_FAILED : K_RETX;
                  opeer_ff   <= cur.peer;
                  oseq_ff    <= cur.seq;
                  ohandle_ff <= cur.handle;
                  olast_ff   <= !more_after;
               end
               idx_ff <= idx_ff + OW'(1);
               if (walk_end) state_ff <= S_PURGE;
            end
            // inbound purge happens this cycle; wait only for a held result
            S_PURGE: state_ff <= (ov_ff && rsp_stall) ? S_DRAIN : S_IDLE;
            S_DRAIN: if (!ov_ff || !rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("item accepted while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_out_seq)))
      else $error("result changed under stall");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last && state_ff == S_DRAIN) |=> (state_ff == S_IDLE))
      else $error("block not idle after last result");
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      (next_seq_ff != $past(next_seq_ff)) |-> (rsp_valid && rsp_kind == K_TX_NEW))
      else $error("sequence advanced without a new transmit");
`endif

endmodule
